// ===== src/spectrum_bar_ballistics_unit_assert.svh =====
// assertion macros used by the spectrum bar ballistics rtl
`ifndef SPECTRUM_BAR_BALLISTICS_UNIT_ASSERT_SVH
`define SPECTRUM_BAR_BALLISTICS_UNIT_ASSERT_SVH

// same-cycle implication
`define SPBB_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SPBB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/spbb_pkg.sv =====
// types, constants and emphasis table of the spectrum bar ballistics unit
package spbb_pkg;

    localparam int BAR_COUNT       = 64;
    localparam int IDX_W           = 6;
    localparam int EMPHASIS_TENTHS = 13;
    localparam int EMPH_W          = 9;
    localparam int ROM_DEPTH       = 257;
    localparam logic [EMPH_W-1:0] GATE_Q8   = 9'd26;
    localparam logic [EMPH_W-1:0] RATIO_MAX = 9'd256;

    typedef enum logic [2:0] {
        CFG_DB_FLOOR     = 3'd0,
        CFG_DB_CEIL      = 3'd1,
        CFG_INVERSE_SPAN = 3'd2,
        CFG_BAR_ROWS     = 3'd3,
        CFG_FAST_ATTACK  = 3'd4,
        CFG_SLOW_ATTACK  = 3'd5,
        CFG_DECAY_RATE   = 3'd6,
        CFG_BARS_IN_USE  = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic signed [15:0] db_floor;
        logic signed [15:0] db_ceil;
        logic [15:0]        inverse_span;
        logic [7:0]         bar_rows;
        logic [8:0]         fast_attack;
        logic [8:0]         slow_attack;
        logic [8:0]         decay_rate;
        logic [6:0]         bars_in_use;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        db_floor:     16'shC400,
        db_ceil:      16'shEE00,
        inverse_span: 16'd1560,
        bar_rows:     8'd20,
        fast_attack:  9'd154,
        slow_attack:  9'd38,
        decay_rate:   9'd36,
        bars_in_use:  7'd26
    };

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic             skip;
        logic [15:0]      target;
    } t_tgt_item;

    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [15:0]      level;
        logic [15:0]      target;
        logic             skip;
    } t_bar_result;

    typedef logic [EMPH_W-1:0] t_emph_rom [ROM_DEPTH];

    // (v/256)^k in q1.30, truncated after each product
    function automatic logic [63:0] pow_q30(input logic [8:0] v, input int k);
        logic [63:0] base;
        logic [63:0] acc;
        base = {55'd0, v} << 22;
        acc  = 64'd1 << 30;
        for (int i = 0; i < k; i++) begin
            acc = (acc * base) >> 30;
        end
        return acc;
    endfunction

    function automatic t_emph_rom build_emph_rom();
        t_emph_rom   rom;
        logic [63:0] p10 [ROM_DEPTH];
        logic [63:0] a;
        int          y;
        for (int v = 0; v < ROM_DEPTH; v++) begin
            p10[v] = pow_q30(9'(v), 10);
        end
        y = 0;
        for (int v = 0; v < ROM_DEPTH; v++) begin
            a = pow_q30(9'(v), EMPHASIS_TENTHS);
            while (y < ROM_DEPTH - 1 && p10[y + 1] <= a) begin
                y++;
            end
            rom[v] = EMPH_W'(y);
        end
        return rom;
    endfunction

    localparam t_emph_rom EMPH_ROM = build_emph_rom();

endpackage

// ===== src/spbb_target.sv =====
// clamp, ratio scaling, emphasis and row scaling stages giving the target height
module spbb_target (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [spbb_pkg::IDX_W-1:0]     i_bar_index,
    input  logic signed [15:0]             i_band_db,
    input  spbb_pkg::t_cfg                 i_cfg,
    output spbb_pkg::t_tgt_item            o_item
);

    logic signed [15:0]            w_clamp_lo;
    logic signed [15:0]            w_clamp;
    logic signed [16:0]            w_diff;
    logic [15:0]                   n1_diff;
    logic                          n1_skip;

    logic                          r1_valid;
    logic [spbb_pkg::IDX_W-1:0]    r1_idx;
    logic                          r1_skip;
    logic [15:0]                   r1_diff;

    logic [31:0]                   w_prod;
    logic [32:0]                   w_round;
    logic [16:0]                   w_ratio_raw;
    logic [spbb_pkg::EMPH_W-1:0]   n2_ratio;

    logic                          r2_valid;
    logic [spbb_pkg::IDX_W-1:0]    r2_idx;
    logic                          r2_skip;
    logic [spbb_pkg::EMPH_W-1:0]   r2_ratio;

    logic [spbb_pkg::EMPH_W-1:0]   w_emph;
    logic [spbb_pkg::EMPH_W-1:0]   w_gated;
    logic [16:0]                   w_tgt;

    logic                          r3_valid;
    logic [spbb_pkg::IDX_W-1:0]    r3_idx;
    logic                          r3_skip;
    logic [15:0]                   r3_target;

    // stage 1: clamp to floor and ceil, offset from floor, flag bars beyond bars_in_use
    always_comb begin
        w_clamp_lo = (i_band_db < i_cfg.db_floor) ? i_cfg.db_floor : i_band_db;
        w_clamp    = (w_clamp_lo > i_cfg.db_ceil) ? i_cfg.db_ceil : w_clamp_lo;
        w_diff     = $signed({w_clamp[15], w_clamp}) -
                     $signed({i_cfg.db_floor[15], i_cfg.db_floor});
        n1_diff    = w_diff[16] ? 16'd0 : w_diff[15:0];
        n1_skip    = ({1'b0, i_bar_index} >= i_cfg.bars_in_use);
    end

    // stage 2: scale by reciprocal span, round, saturate
    always_comb begin
        w_prod      = r1_diff * i_cfg.inverse_span;
        w_round     = {1'b0, w_prod} + 33'd32768;
        w_ratio_raw = w_round[32:16];
        n2_ratio    = (w_ratio_raw > {8'd0, spbb_pkg::RATIO_MAX}) ?
                      spbb_pkg::RATIO_MAX : w_ratio_raw[spbb_pkg::EMPH_W-1:0];
    end

    // stage 3: emphasis, gate, rows
    always_comb begin
        w_emph  = spbb_pkg::EMPH_ROM[r2_ratio];
        w_gated = (w_emph < spbb_pkg::GATE_Q8) ? '0 : w_emph;
        w_tgt   = {8'd0, w_gated} * {9'd0, i_cfg.bar_rows};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_idx    <= i_bar_index;
            r1_skip   <= n1_skip;
            r1_diff   <= n1_diff;
            r2_idx    <= r1_idx;
            r2_skip   <= r1_skip;
            r2_ratio  <= n2_ratio;
            r3_idx    <= r2_idx;
            r3_skip   <= r2_skip;
            r3_target <= w_tgt[15:0];
        end
    end

    assign o_item.valid  = r3_valid;
    assign o_item.idx    = r3_idx;
    assign o_item.skip   = r3_skip;
    assign o_item.target = r3_target;

endmodule

// ===== src/spbb_level.sv =====
// bar level store with read-modify-write, forwarding and attack/decay update
`include "spectrum_bar_ballistics_unit_assert.svh"

module spbb_level (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  spbb_pkg::t_tgt_item    i_item,
    input  spbb_pkg::t_cfg         i_cfg,
    output spbb_pkg::t_bar_result  o_result
);

    logic [15:0]                     r_mem [spbb_pkg::BAR_COUNT];
    logic [spbb_pkg::BAR_COUNT-1:0]  r_vld;

    logic                            r4_valid;
    logic [spbb_pkg::IDX_W-1:0]      r4_idx;
    logic                            r4_skip;
    logic [15:0]                     r4_target;
    logic [15:0]                     r4_rd;
    logic                            r4_byp;
    logic [15:0]                     r4_byp_data;

    logic [15:0]                     w_level;
    logic                            w_rise;
    logic [15:0]                     w_mag;
    logic [18:0]                     w_mag5;
    logic                            w_big;
    logic [8:0]                      w_frac;
    logic [24:0]                     w_prod;
    logic [17:0]                     w_up_sum;
    logic [15:0]                     w_next_up;
    logic [25:0]                     w_drop_sum;
    logic [17:0]                     w_drop;
    logic [15:0]                     w_next_dn;
    logic [15:0]                     w_next;
    logic                            w_wr;

    always_comb begin
        w_level = r4_byp ? r4_byp_data : r4_rd;
        w_rise  = (r4_target > w_level);
        w_mag   = w_rise ? (r4_target - w_level) : (w_level - r4_target);
        w_mag5  = {3'd0, w_mag} * 19'd5;
        w_big   = (w_mag5 > {3'd0, i_cfg.bar_rows, 8'd0});
        priority if (!w_rise) begin
            w_frac = i_cfg.decay_rate;
        end else if (w_big) begin
            w_frac = i_cfg.fast_attack;
        end else begin
            w_frac = i_cfg.slow_attack;
        end
        w_prod     = {9'd0, w_mag} * {16'd0, w_frac};
        w_up_sum   = {2'd0, w_level} + {1'b0, w_prod[24:8]};
        w_next_up  = (w_up_sum[17:16] != 2'd0) ? 16'hFFFF : w_up_sum[15:0];
        w_drop_sum = {1'b0, w_prod} + 26'd255;
        w_drop     = w_drop_sum[25:8];
        w_next_dn  = (w_drop >= {2'd0, w_level}) ? 16'd0 : (w_level - w_drop[15:0]);
        w_next     = w_rise ? w_next_up : w_next_dn;
        w_wr       = i_en && r4_valid && !r4_skip;
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r4_idx] <= w_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_wr) begin
            r_vld[r4_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
            r4_byp   <= 1'b0;
        end else if (i_en) begin
            r4_valid <= i_item.valid;
            r4_byp   <= i_item.valid && r4_valid && !r4_skip && (r4_idx == i_item.idx);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_idx      <= i_item.idx;
            r4_skip     <= i_item.skip;
            r4_target   <= i_item.target;
            r4_rd       <= r_vld[i_item.idx] ? r_mem[i_item.idx] : 16'd0;
            r4_byp_data <= w_next;
        end
    end

    assign o_result.valid  = r4_valid;
    assign o_result.idx    = r4_idx;
    assign o_result.level  = r4_skip ? w_level : w_next;
    assign o_result.target = r4_target;
    assign o_result.skip   = r4_skip;

    `SPBB_ASSERT_NOW(a_byp_has_item, i_clk, i_rst_n, r4_byp, r4_valid, "forward without item")
    `SPBB_ASSERT_NEXT(a_wr_sets_vld, i_clk, i_rst_n, w_wr, r_vld[$past(r4_idx)], "entry not marked")
    `SPBB_ASSERT_NOW(a_rise_up, i_clk, i_rst_n, r4_valid && w_rise, w_next >= w_level, "rise fell")
    `SPBB_ASSERT_NOW(a_fall_dn, i_clk, i_rst_n, r4_valid && !w_rise, w_next <= w_level, "decay rose")

endmodule

// ===== src/spectrum_bar_ballistics_unit.sv =====
// top level of the spectrum bar ballistics unit: config registers, pipeline, output register
//
// usage
//   s_axis: one request per band, tdata = bar_index [5:0], band_db [21:6] (signed q8.8).
//   m_axis: one result per request, tdata = bar_number [5:0], display_level [21:6],
//   target_level [37:22]; tuser = skipped.
//   cfg: write i_cfg_data to register i_cfg_index when i_cfg_valid is high; o_cfg_ready
//   is always high. write only while no request is in flight.
// pipeline
//   one request per cycle sustained unless m_axis stalls; a result shows on m_axis
//   after its request passes clamp, ratio multiply, emphasis and rows multiply, bar
//   store read-modify-write and output register. requests to the same bar back to
//   back are forwarded around the store read so every update sees the previous one.
// reset
//   i_rst_n low restores register defaults and clears all bar levels to zero at once
//   through per-bar valid flags; requests may follow in the next cycle.
// stall
//   when m_axis_tready is low with a result held, the whole pipeline freezes and
//   s_axis_tready drops; nothing is lost or repeated.
module spectrum_bar_ballistics_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // bar_index, band_db
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // bar_number, display_level, target_level
    output logic [0:0]  m_axis_tuser,   // skipped
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    spbb_pkg::t_cfg         r_cfg;
    spbb_pkg::t_tgt_item    w_item;
    spbb_pkg::t_bar_result  w_res;
    logic                   w_en;
    logic                   r_out_valid;
    logic [39:0]            r_out_data;
    logic                   r_out_skip;

    assign w_en          = !r_out_valid || m_axis_tready;
    assign s_axis_tready = w_en;
    assign o_cfg_ready   = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= spbb_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (spbb_pkg::t_cfg_reg'(i_cfg_index))
                spbb_pkg::CFG_DB_FLOOR:     r_cfg.db_floor     <= $signed(i_cfg_data);
                spbb_pkg::CFG_DB_CEIL:      r_cfg.db_ceil      <= $signed(i_cfg_data);
                spbb_pkg::CFG_INVERSE_SPAN: r_cfg.inverse_span <= i_cfg_data;
                spbb_pkg::CFG_BAR_ROWS:     r_cfg.bar_rows     <= i_cfg_data[7:0];
                spbb_pkg::CFG_FAST_ATTACK:  r_cfg.fast_attack  <= i_cfg_data[8:0];
                spbb_pkg::CFG_SLOW_ATTACK:  r_cfg.slow_attack  <= i_cfg_data[8:0];
                spbb_pkg::CFG_DECAY_RATE:   r_cfg.decay_rate   <= i_cfg_data[8:0];
                spbb_pkg::CFG_BARS_IN_USE:  r_cfg.bars_in_use  <= i_cfg_data[6:0];
            endcase
        end
    end

    spbb_target u_target (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (s_axis_tvalid),
        .i_bar_index (s_axis_tdata[5:0]),
        .i_band_db   ($signed(s_axis_tdata[21:6])),
        .i_cfg       (r_cfg),
        .o_item      (w_item)
    );

    spbb_level u_level (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_item   (w_item),
        .i_cfg    (r_cfg),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data <= {2'd0, w_res.target, w_res.level, w_res.idx};
            r_out_skip <= w_res.skip;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_skip;

endmodule
